@@ rtl/tiled_framebuffer_pixel_writer_core_defines.svh @@
// assertion macros shared by the pixel writer rtl
`ifndef TILED_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH
`define TILED_FRAMEBUFFER_PIXEL_WRITER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TFBPW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TFBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tfbpw_pkg.sv @@
// types, constants and pixel conversions for the tiled framebuffer pixel writer
package tfbpw_pkg;

    localparam int MAX_DIM           = 2048;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CW    = 11;
    localparam int DW    = 12;
    localparam int QW    = $clog2(MAX_DIM);
    localparam int PW    = CW + DW;
    localparam int FBW   = 22;
    localparam int PXW   = 32;
    localparam int COLW  = 24;
    localparam int PIDXW = 8;
    localparam int FMTW  = 2;
    localparam int CMDW  = 2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 12;

    localparam int TILE_SH    = 5;
    localparam int TILE_LOW_W = 10;
    localparam int XT_W       = CW - TILE_SH;
    localparam int PT_W       = DW + 1 - TILE_SH;
    localparam int TM_W       = XT_W + PT_W;
    localparam int FB_HI_W    = FBW - TILE_LOW_W;

    localparam int IN_X_LSB    = 0;
    localparam int IN_Y_LSB    = IN_X_LSB + CW;
    localparam int IN_RAW_LSB  = IN_Y_LSB + CW;
    localparam int IN_PIDX_LSB = IN_RAW_LSB + PXW;
    localparam int IN_PCOL_LSB = IN_PIDX_LSB + PIDXW;
    localparam int IN_W        = IN_PCOL_LSB + COLW;
    localparam int S_TDATA_W   = ((IN_W + 7) / 8) * 8;

    localparam int RES_W     = CW + CW + FBW + PXW;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [DW-1:0]   RST_DST_WIDTH  = 12'd1280;
    localparam logic [DW-1:0]   RST_DST_HEIGHT = 12'd720;
    localparam logic [DW-1:0]   RST_SRC_WIDTH  = 12'd320;
    localparam logic [DW-1:0]   RST_SRC_HEIGHT = 12'd240;

    typedef enum logic [CMDW-1:0] {
        CMD_MAP       = 2'd0,
        CMD_CONVERT   = 2'd1,
        CMD_PAL_WRITE = 2'd2
    } t_cmd;

    typedef enum logic [FMTW-1:0] {
        FMT_RGB565  = 2'd0,
        FMT_PALETTE = 2'd1,
        FMT_WORD    = 2'd2
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DST_WIDTH  = 3'd0,
        REG_DST_HEIGHT = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_SRC_HEIGHT = 3'd3,
        REG_PIXEL_FMT  = 3'd4
    } t_cfg_reg;

    localparam logic [FMTW-1:0] RST_PIXEL_FMT = FMT_RGB565;

    // 5/6/5 channels widened by bit replication, laid out b,g,r,0
    function automatic logic [PXW-1:0] f_from_565(input logic [15:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {p[15:11], p[15:13]};
        g = {p[10:5], p[10:9]};
        b = {p[4:0], p[4:2]};
        return {b, g, r, 8'h00};
    endfunction

    function automatic logic [PXW-1:0] f_from_color(input logic [COLW-1:0] c);
        return {c[7:0], c[15:8], c[23:16], 8'h00};
    endfunction

    function automatic logic [PXW-1:0] f_from_word(input logic [PXW-1:0] w);
        return {w[15:8], w[23:16], w[31:24], 8'h00};
    endfunction

endpackage

@@ rtl/tfbpw_scale.sv @@
// pipelined restoring divider giving one nearest-neighbour source coordinate
module tfbpw_scale (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [tfbpw_pkg::PW-1:0] i_prod,
    input  logic [tfbpw_pkg::DW-1:0] i_div,
    output logic [tfbpw_pkg::CW-1:0] o_coord
);
    import tfbpw_pkg::*;

    localparam int CMPW = ((PW > DW + QW) ? PW : DW + QW) + 1;

    logic [PW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_quo  [QW+1];
    logic [DW-1:0] r_div  [QW+1];
    logic          r_zero [QW+1];
    logic          r_sat  [QW+1];

    logic [PW-1:0] n_rem  [QW+1];
    logic [QW-1:0] n_quo  [QW+1];
    logic [DW-1:0] n_div  [QW+1];
    logic          n_zero [QW+1];
    logic          n_sat  [QW+1];

    // stage 0 flags overflow and a zero divisor, each later stage settles one quotient bit
    always_comb begin
        n_rem[0]  = i_prod;
        n_quo[0]  = '0;
        n_div[0]  = i_div;
        n_zero[0] = (i_div == '0);
        n_sat[0]  = (CMPW'(i_prod) >= (CMPW'(i_div) << QW));
        for (int j = 1; j <= QW; j++) begin
            n_div[j]  = r_div[j-1];
            n_zero[j] = r_zero[j-1];
            n_sat[j]  = r_sat[j-1];
            n_rem[j]  = r_rem[j-1];
            n_quo[j]  = r_quo[j-1];
            if (CMPW'(r_rem[j-1]) >= (CMPW'(r_div[j-1]) << (QW - j))) begin
                n_rem[j] = PW'(CMPW'(r_rem[j-1]) - (CMPW'(r_div[j-1]) << (QW - j)));
                n_quo[j] = r_quo[j-1] | (QW'(1) << (QW - j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j <= QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
                r_div[j]  <= n_div[j];
                r_zero[j] <= n_zero[j];
                r_sat[j]  <= n_sat[j];
            end
        end
    end

    assign o_coord = r_zero[QW] ? '0
                   : r_sat[QW]  ? CW'(MAX_DIM - 1)
                   : CW'(r_quo[QW]);

endmodule

@@ rtl/tiled_framebuffer_pixel_writer_core.sv @@
// top level of the tiled framebuffer pixel writer
// Takes one command per clock while the skid register is empty and returns its
// result through the output register. An address command scales the destination
// position to its nearest source position (dst * src_size / dst_size, truncated,
// saturated at 2047, a zero destination size giving zero) and gives the 32x32
// tiled framebuffer word index; a convert command turns a raw pixel into a b,g,r,0
// word according to the pixel format register; a palette write loads one entry
// and gives no result. The two dividers settle one quotient bit per pipeline
// stage; the palette is read and written in the same stage, so a write is seen
// by every later convert. A palette entry never written reads undefined. A
// two-deep output register lets the input keep flowing while one result waits.
// Configuration must be written only while the block is idle; the block does not enforce it.

`include "tiled_framebuffer_pixel_writer_core_defines.svh"

module tiled_framebuffer_pixel_writer_core #(
    parameter int PALETTE_DEPTH = tfbpw_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tfbpw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tfbpw_pkg::CFG_DW-1:0]        i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dst_x, dst_y, raw_pixel, pal_index, pal_color, zero pad
    input  logic [tfbpw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic [tfbpw_pkg::CMDW-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // src_x, src_y, fb_index, pixel_word, zero pad
    output logic [tfbpw_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import tfbpw_pkg::*;

    localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // configuration
    logic [DW-1:0]   r_dst_width;
    logic [DW-1:0]   r_dst_height;
    logic [DW-1:0]   r_src_width;
    logic [DW-1:0]   r_src_height;
    logic [FMTW-1:0] r_pixel_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_pixel_fmt  <= RST_PIXEL_FMT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                REG_PIXEL_FMT:  r_pixel_fmt  <= i_cfg_data[FMTW-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves while the skid register is empty
    logic r_skid_valid;
    logic w_adv;

    assign w_adv         = !r_skid_valid;
    assign s_axis_tready = w_adv;

    // stage 0: input register
    logic             r_s0_valid;
    logic [CMDW-1:0]  r_s0_cmd;
    logic [CW-1:0]    r_s0_x;
    logic [CW-1:0]    r_s0_y;
    logic [PXW-1:0]   r_s0_raw;
    logic [PIDXW-1:0] r_s0_pidx;
    logic [COLW-1:0]  r_s0_pcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_cmd  <= s_axis_tuser;
            r_s0_x    <= s_axis_tdata[IN_X_LSB +: CW];
            r_s0_y    <= s_axis_tdata[IN_Y_LSB +: CW];
            r_s0_raw  <= s_axis_tdata[IN_RAW_LSB +: PXW];
            r_s0_pidx <= s_axis_tdata[IN_PIDX_LSB +: PIDXW];
            r_s0_pcol <= s_axis_tdata[IN_PCOL_LSB +: COLW];
        end
    end

    // stage 1: products, palette access, direct conversions
    logic [DW:0]      w_pitch_sum;
    logic [PT_W-1:0]  w_pitch_tiles;
    logic [PXW-1:0]   w_direct_pix;
    logic             w_rd_ok;
    logic             w_wr_ok;

    assign w_pitch_sum   = (DW+1)'(r_dst_width) + (DW+1)'((1 << TILE_SH) - 1);
    assign w_pitch_tiles = w_pitch_sum[DW:TILE_SH];
    assign w_rd_ok = ({1'b0, r_s0_raw[PIDXW-1:0]} < (PIDXW+1)'(PALETTE_DEPTH));
    assign w_wr_ok = ({1'b0, r_s0_pidx} < (PIDXW+1)'(PALETTE_DEPTH));

    always_comb begin
        unique case (r_pixel_fmt)
            FMT_RGB565:  w_direct_pix = f_from_565(r_s0_raw[15:0]);
            FMT_PALETTE: w_direct_pix = '0;
            default:     w_direct_pix = f_from_word(r_s0_raw);
        endcase
    end

    logic [COLW-1:0] r_pal_mem [PALETTE_DEPTH];
    logic [COLW-1:0] r_s1_pal_color;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_pal_color <= r_pal_mem[r_s0_raw[PAW-1:0]];
            if (r_s0_valid && r_s0_cmd == CMD_PAL_WRITE && w_wr_ok) begin
                r_pal_mem[r_s0_pidx[PAW-1:0]] <= r_s0_pcol;
            end
        end
    end

    logic                  r_s1_valid;
    logic [CMDW-1:0]       r_s1_cmd;
    logic [PW-1:0]         r_s1_prod_x;
    logic [PW-1:0]         r_s1_prod_y;
    logic [TM_W-1:0]       r_s1_tile_mul;
    logic [XT_W-1:0]       r_s1_x_tile;
    logic [TILE_LOW_W-1:0] r_s1_low;
    logic [PXW-1:0]        r_s1_pix;
    logic                  r_s1_use_pal;
    logic                  r_s1_pal_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd      <= r_s0_cmd;
            r_s1_prod_x   <= PW'(r_s0_x) * PW'(r_src_width);
            r_s1_prod_y   <= PW'(r_s0_y) * PW'(r_src_height);
            r_s1_tile_mul <= TM_W'(r_s0_y[CW-1:TILE_SH]) * TM_W'(w_pitch_tiles);
            r_s1_x_tile   <= r_s0_x[CW-1:TILE_SH];
            // swizzled offset inside one 32x32 tile
            r_s1_low      <= {r_s0_y[4:1], r_s0_x[4] ^ r_s0_y[3], r_s0_x[3:2],
                              r_s0_y[0], r_s0_x[1:0]};
            r_s1_pix      <= w_direct_pix;
            r_s1_use_pal  <= (r_pixel_fmt == FMT_PALETTE);
            r_s1_pal_ok   <= w_rd_ok;
        end
    end

    // dividers
    logic [CW-1:0] w_src_x;
    logic [CW-1:0] w_src_y;

    tfbpw_scale u_scale_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_prod  (r_s1_prod_x),
        .i_div   (r_dst_width),
        .o_coord (w_src_x)
    );

    tfbpw_scale u_scale_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_prod  (r_s1_prod_y),
        .i_div   (r_dst_height),
        .o_coord (w_src_y)
    );

    // side line alongside the dividers
    logic            r_sd_valid [QW+1];
    logic [CMDW-1:0] r_sd_cmd   [QW+1];
    logic [FBW-1:0]  r_sd_fb    [QW+1];
    logic [PXW-1:0]  r_sd_pix   [QW+1];

    logic [FBW-1:0]  w_fb_index;
    logic [PXW-1:0]  w_conv_pix;

    assign w_fb_index = {FB_HI_W'(r_s1_tile_mul) + FB_HI_W'(r_s1_x_tile), r_s1_low};
    assign w_conv_pix = !r_s1_use_pal ? r_s1_pix
                      : r_s1_pal_ok   ? f_from_color(r_s1_pal_color)
                      : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QW; j++) begin
                r_sd_valid[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sd_valid[0] <= r_s1_valid;
            for (int j = 1; j <= QW; j++) begin
                r_sd_valid[j] <= r_sd_valid[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd_cmd[0] <= r_s1_cmd;
            r_sd_fb[0]  <= w_fb_index;
            r_sd_pix[0] <= w_conv_pix;
            for (int j = 1; j <= QW; j++) begin
                r_sd_cmd[j] <= r_sd_cmd[j-1];
                r_sd_fb[j]  <= r_sd_fb[j-1];
                r_sd_pix[j] <= r_sd_pix[j-1];
            end
        end
    end

    // result assembly
    logic             w_res_valid;
    logic [RES_W-1:0] w_res;

    always_comb begin
        w_res_valid = 1'b0;
        w_res       = '0;
        unique case (r_sd_cmd[QW])
            CMD_MAP: begin
                w_res_valid = r_sd_valid[QW];
                w_res       = {{PXW{1'b0}}, r_sd_fb[QW], w_src_y, w_src_x};
            end
            CMD_CONVERT: begin
                w_res_valid = r_sd_valid[QW];
                w_res       = {r_sd_pix[QW], {(FBW + 2 * CW){1'b0}}};
            end
            default: ;
        endcase
    end

    // output register and skid register
    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data;
    logic [RES_W-1:0] r_skid_data;
    logic             n_out_valid;
    logic [RES_W-1:0] n_out_data;
    logic             n_skid_valid;
    logic [RES_W-1:0] n_skid_data;
    logic             w_push;

    assign w_push = w_adv && w_res_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        priority if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_push;
                n_out_data  = w_res;
            end
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, r_out_data};

    `TFBPW_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with output empty")
    `TFBPW_ASSERT_SAME(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && !m_axis_tready), "skid filled without an output stall")
    `TFBPW_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !m_axis_tready, r_skid_valid, "skid emptied while output stalled")

endmodule
